// File: hdl/tacm_pkg.sv
package tacm_pkg;

	localparam int TOUCH_BITS   = 12;
	localparam int DISPLAY_BITS = 11;

	localparam int W_DIVIDER = 26;
	localparam int W_COEF    = 25;
	localparam int W_OFFSET  = 38;

	localparam int TD_W   = TOUCH_BITS + 1;
	localparam int DD_W   = DISPLAY_BITS + 1;
	localparam int XD_W   = (TD_W > DD_W) ? TD_W : DD_W;
	localparam int XP_W   = 2 * XD_W;
	localparam int XS_W   = XP_W + 1;
	localparam int TP_W   = TOUCH_BITS + DISPLAY_BITS;
	localparam int TPD_W  = TP_W + 1;
	localparam int CT_W   = TPD_W + TOUCH_BITS + 1;
	localparam int CS_W   = CT_W + 2;

	typedef logic [TOUCH_BITS-1:0]          touch_t;
	typedef logic [DISPLAY_BITS-1:0]        disp_t;
	typedef logic signed [XD_W-1:0]         diff_t;
	typedef logic [TP_W-1:0]                prod_t;
	typedef logic signed [TPD_W-1:0]        pdiff_t;
	typedef logic signed [XP_W-1:0]         cross_t;
	typedef logic signed [XS_W-1:0]         sub_t;
	typedef logic signed [CT_W-1:0]         cterm_t;
	typedef logic signed [CS_W-1:0]         csum_t;
	typedef logic signed [W_DIVIDER-1:0]    divider_t;
	typedef logic signed [W_COEF-1:0]       coef_t;
	typedef logic signed [W_OFFSET-1:0]     offset_t;

	// stage 1 -> stage 2: coordinate differences and touch*display products
	typedef struct packed {
		diff_t          tx0;
		diff_t          tx1;
		diff_t          ty0;
		diff_t          ty1;
		diff_t          dx0;
		diff_t          dx1;
		diff_t          dy0;
		diff_t          dy1;
		prod_t [5:0]    px;
		prod_t [5:0]    py;
		touch_t [2:0]   ty;
	} s1_t;

	// stage 3 -> stage 4: cross differences and offset terms
	typedef struct packed {
		sub_t           div;
		sub_t           a;
		sub_t           b;
		sub_t           d;
		sub_t           e;
		cterm_t [2:0]   cx;
		cterm_t [2:0]   cy;
	} s3_t;

	function automatic diff_t tdiff(input touch_t p, input touch_t q);
		return diff_t'($signed({1'b0, p})) - diff_t'($signed({1'b0, q}));
	endfunction

	function automatic diff_t ddiff(input disp_t p, input disp_t q);
		return diff_t'($signed({1'b0, p})) - diff_t'($signed({1'b0, q}));
	endfunction

	function automatic prod_t tdmul(input touch_t p, input disp_t q);
		return prod_t'(p) * prod_t'(q);
	endfunction

endpackage

// File: hdl/tacm_diff.sv
module tacm_diff import tacm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  touch_t touch0_x,
	input  touch_t touch0_y,
	input  touch_t touch1_x,
	input  touch_t touch1_y,
	input  touch_t touch2_x,
	input  touch_t touch2_y,
	input  disp_t  disp0_x,
	input  disp_t  disp0_y,
	input  disp_t  disp1_x,
	input  disp_t  disp1_y,
	input  disp_t  disp2_x,
	input  disp_t  disp2_y,
	output logic   v_s1,
	output s1_t    d_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d_s1.tx0   <= tdiff(touch0_x, touch2_x);
		d_s1.tx1   <= tdiff(touch1_x, touch2_x);
		d_s1.ty0   <= tdiff(touch0_y, touch2_y);
		d_s1.ty1   <= tdiff(touch1_y, touch2_y);
		d_s1.dx0   <= ddiff(disp0_x, disp2_x);
		d_s1.dx1   <= ddiff(disp1_x, disp2_x);
		d_s1.dy0   <= ddiff(disp0_y, disp2_y);
		d_s1.dy1   <= ddiff(disp1_y, disp2_y);
		d_s1.px[0] <= tdmul(touch2_x, disp1_x);
		d_s1.px[1] <= tdmul(touch1_x, disp2_x);
		d_s1.px[2] <= tdmul(touch0_x, disp2_x);
		d_s1.px[3] <= tdmul(touch2_x, disp0_x);
		d_s1.px[4] <= tdmul(touch1_x, disp0_x);
		d_s1.px[5] <= tdmul(touch0_x, disp1_x);
		d_s1.py[0] <= tdmul(touch2_x, disp1_y);
		d_s1.py[1] <= tdmul(touch1_x, disp2_y);
		d_s1.py[2] <= tdmul(touch0_x, disp2_y);
		d_s1.py[3] <= tdmul(touch2_x, disp0_y);
		d_s1.py[4] <= tdmul(touch1_x, disp0_y);
		d_s1.py[5] <= tdmul(touch0_x, disp1_y);
		d_s1.ty[0] <= touch0_y;
		d_s1.ty[1] <= touch1_y;
		d_s1.ty[2] <= touch2_y;
	end

endmodule

// File: hdl/tacm_cross.sv
module tacm_cross import tacm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic v_s1,
	input  s1_t  d_s1,
	output logic v_s3,
	output s3_t  d_s3
);

	logic           v_s2;
	cross_t [9:0]   xp_s2;
	pdiff_t [2:0]   cdx_s2;
	pdiff_t [2:0]   cdy_s2;
	touch_t [2:0]   ty_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 2: cross products, touch*display differences
	always_ff @(posedge clk) begin
		xp_s2[0] <= cross_t'(d_s1.tx0) * cross_t'(d_s1.ty1);
		xp_s2[1] <= cross_t'(d_s1.tx1) * cross_t'(d_s1.ty0);
		xp_s2[2] <= cross_t'(d_s1.dx0) * cross_t'(d_s1.ty1);
		xp_s2[3] <= cross_t'(d_s1.dx1) * cross_t'(d_s1.ty0);
		xp_s2[4] <= cross_t'(d_s1.tx0) * cross_t'(d_s1.dx1);
		xp_s2[5] <= cross_t'(d_s1.dx0) * cross_t'(d_s1.tx1);
		xp_s2[6] <= cross_t'(d_s1.dy0) * cross_t'(d_s1.ty1);
		xp_s2[7] <= cross_t'(d_s1.dy1) * cross_t'(d_s1.ty0);
		xp_s2[8] <= cross_t'(d_s1.tx0) * cross_t'(d_s1.dy1);
		xp_s2[9] <= cross_t'(d_s1.dy0) * cross_t'(d_s1.tx1);
		for (int k = 0; k < 3; k++) begin
			cdx_s2[k] <= pdiff_t'(d_s1.px[2*k]) - pdiff_t'(d_s1.px[2*k+1]);
			cdy_s2[k] <= pdiff_t'(d_s1.py[2*k]) - pdiff_t'(d_s1.py[2*k+1]);
		end
		ty_s2 <= d_s1.ty;
	end

	// stage 3: cross differences, offset terms
	always_ff @(posedge clk) begin
		d_s3.div <= sub_t'(xp_s2[0]) - sub_t'(xp_s2[1]);
		d_s3.a   <= sub_t'(xp_s2[2]) - sub_t'(xp_s2[3]);
		d_s3.b   <= sub_t'(xp_s2[4]) - sub_t'(xp_s2[5]);
		d_s3.d   <= sub_t'(xp_s2[6]) - sub_t'(xp_s2[7]);
		d_s3.e   <= sub_t'(xp_s2[8]) - sub_t'(xp_s2[9]);
		for (int k = 0; k < 3; k++) begin
			d_s3.cx[k] <= cterm_t'(cdx_s2[k]) * cterm_t'($signed({1'b0, ty_s2[k]}));
			d_s3.cy[k] <= cterm_t'(cdy_s2[k]) * cterm_t'($signed({1'b0, ty_s2[k]}));
		end
	end

endmodule

// File: hdl/tacm_out.sv
module tacm_out import tacm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     v_s3,
	input  s3_t      d_s3,
	output logic     v_s4,
	output logic     degen_s4,
	output divider_t div_s4,
	output coef_t    a_s4,
	output coef_t    b_s4,
	output offset_t  c_s4,
	output coef_t    d_s4,
	output coef_t    e_s4,
	output offset_t  f_s4
);

	logic  degen;
	csum_t csx;
	csum_t csy;

	assign degen = (d_s3.div == '0);
	assign csx = csum_t'(d_s3.cx[0]) + csum_t'(d_s3.cx[1]) + csum_t'(d_s3.cx[2]);
	assign csy = csum_t'(d_s3.cy[0]) + csum_t'(d_s3.cy[1]) + csum_t'(d_s3.cy[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		degen_s4 <= degen;
		div_s4   <= divider_t'(d_s3.div);
		a_s4     <= degen ? '0 : coef_t'(d_s3.a);
		b_s4     <= degen ? '0 : coef_t'(d_s3.b);
		c_s4     <= degen ? '0 : offset_t'(csx);
		d_s4     <= degen ? '0 : coef_t'(d_s3.d);
		e_s4     <= degen ? '0 : coef_t'(d_s3.e);
		f_s4     <= degen ? '0 : offset_t'(csy);
	end

endmodule

// File: hdl/touch_affine_calibration_matrix.sv
// The done strobe is start carried through the stage valid registers v_s1, v_s2, v_s3 and v_s4.
// Throughput: one item per cycle; busy is never raised, the four-stage
// multiply/subtract pipeline takes a new item at every edge.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (arst_n low, asynchronous) clears all stage valid bits; items in
// flight are dropped.
module touch_affine_calibration_matrix import tacm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  touch_t   touch0_x,
	input  touch_t   touch0_y,
	input  touch_t   touch1_x,
	input  touch_t   touch1_y,
	input  touch_t   touch2_x,
	input  touch_t   touch2_y,
	input  disp_t    disp0_x,
	input  disp_t    disp0_y,
	input  disp_t    disp1_x,
	input  disp_t    disp1_y,
	input  disp_t    disp2_x,
	input  disp_t    disp2_y,
	output logic     done,
	output logic     degenerate,
	output divider_t divider,
	output coef_t    coef_a,
	output coef_t    coef_b,
	output offset_t  coef_c,
	output coef_t    coef_d,
	output coef_t    coef_e,
	output offset_t  coef_f
);

	logic v_s1;
	s1_t  d_s1;
	logic v_s3;
	s3_t  d_s3;

	assign busy = 1'b0;

	tacm_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.touch0_x (touch0_x),
		.touch0_y (touch0_y),
		.touch1_x (touch1_x),
		.touch1_y (touch1_y),
		.touch2_x (touch2_x),
		.touch2_y (touch2_y),
		.disp0_x  (disp0_x),
		.disp0_y  (disp0_y),
		.disp1_x  (disp1_x),
		.disp1_y  (disp1_y),
		.disp2_x  (disp2_x),
		.disp2_y  (disp2_y),
		.v_s1     (v_s1),
		.d_s1     (d_s1)
	);

	tacm_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.d_s1   (d_s1),
		.v_s3   (v_s3),
		.d_s3   (d_s3)
	);

	tacm_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s3     (v_s3),
		.d_s3     (d_s3),
		.v_s4     (done),
		.degen_s4 (degenerate),
		.div_s4   (divider),
		.a_s4     (coef_a),
		.b_s4     (coef_b),
		.c_s4     (coef_c),
		.d_s4     (coef_d),
		.e_s4     (coef_e),
		.f_s4     (coef_f)
	);

endmodule

// File: hdl/tacm_chk.sv
module tacm_chk import tacm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input logic     degenerate,
	input divider_t divider,
	input coef_t    coef_a,
	input coef_t    coef_b,
	input offset_t  coef_c,
	input coef_t    coef_d,
	input coef_t    coef_e,
	input offset_t  coef_f
);

	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted item produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without an accepted item");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> divider == '0 && coef_a == '0 && coef_b == '0 &&
			coef_c == '0 && coef_d == '0 && coef_e == '0 && coef_f == '0)
		else $error("degenerate result with nonzero fields");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> divider != '0)
		else $error("zero divider not flagged");

endmodule

bind touch_affine_calibration_matrix tacm_chk u_chk (.*);

// File: tb/tb.sv
module tb;
	import tacm_pkg::*;

	typedef longint trio_t [3];

	typedef struct {
		touch_t t_x [3];
		touch_t t_y [3];
		disp_t  d_x [3];
		disp_t  d_y [3];
	} calib_points_t;

	typedef struct {
		logic     degenerate;
		divider_t divider;
		coef_t    a;
		coef_t    b;
		offset_t  c;
		coef_t    d;
		coef_t    e;
		offset_t  f;
	} calib_matrix_t;

	localparam int T_MAX = (1 << TOUCH_BITS) - 1;
	localparam int D_MAX = (1 << DISPLAY_BITS) - 1;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	touch_t   touch0_x, touch0_y, touch1_x, touch1_y, touch2_x, touch2_y;
	disp_t    disp0_x, disp0_y, disp1_x, disp1_y, disp2_x, disp2_y;
	logic     done;
	logic     degenerate;
	divider_t divider;
	coef_t    coef_a, coef_b, coef_d, coef_e;
	offset_t  coef_c, coef_f;

	touch_affine_calibration_matrix dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.touch0_x   (touch0_x),
		.touch0_y   (touch0_y),
		.touch1_x   (touch1_x),
		.touch1_y   (touch1_y),
		.touch2_x   (touch2_x),
		.touch2_y   (touch2_y),
		.disp0_x    (disp0_x),
		.disp0_y    (disp0_y),
		.disp1_x    (disp1_x),
		.disp1_y    (disp1_y),
		.disp2_x    (disp2_x),
		.disp2_y    (disp2_y),
		.done       (done),
		.degenerate (degenerate),
		.divider    (divider),
		.coef_a     (coef_a),
		.coef_b     (coef_b),
		.coef_c     (coef_c),
		.coef_d     (coef_d),
		.coef_e     (coef_e),
		.coef_f     (coef_f)
	);

	// numerators for one display axis
	function automatic void axis_terms(input trio_t tx, input trio_t ty, input trio_t dv,
			output longint ka, output longint kb, output longint kc);
		ka = (dv[0] - dv[2]) * (ty[1] - ty[2]) - (dv[1] - dv[2]) * (ty[0] - ty[2]);
		kb = (tx[0] - tx[2]) * (dv[1] - dv[2]) - (dv[0] - dv[2]) * (tx[1] - tx[2]);
		kc = (tx[2] * dv[1] - tx[1] * dv[2]) * ty[0]
		   + (tx[0] * dv[2] - tx[2] * dv[0]) * ty[1]
		   + (tx[1] * dv[0] - tx[0] * dv[1]) * ty[2];
	endfunction

	function automatic calib_matrix_t solve_matrix(input calib_points_t p);
		calib_matrix_t m;
		trio_t  tx, ty, dx, dy;
		longint det, ka, kb, kc, kd, ke, kf;
		for (int k = 0; k < 3; k++) begin
			tx[k] = longint'(p.t_x[k]);
			ty[k] = longint'(p.t_y[k]);
			dx[k] = longint'(p.d_x[k]);
			dy[k] = longint'(p.d_y[k]);
		end
		det = (tx[0] - tx[2]) * (ty[1] - ty[2]) - (tx[1] - tx[2]) * (ty[0] - ty[2]);
		axis_terms(tx, ty, dx, ka, kb, kc);
		axis_terms(tx, ty, dy, kd, ke, kf);
		if (det == 0) begin
			ka = 0; kb = 0; kc = 0; kd = 0; ke = 0; kf = 0;
		end
		m.degenerate = (det == 0);
		m.divider    = divider_t'(det);
		m.a          = coef_t'(ka);
		m.b          = coef_t'(kb);
		m.c          = offset_t'(kc);
		m.d          = coef_t'(kd);
		m.e          = coef_t'(ke);
		m.f          = offset_t'(kf);
		return m;
	endfunction

	class matrix_board;
		calib_matrix_t matrix_due [$];
		int errors;
		int results_seen;

		function new();
			errors = 0;
			results_seen = 0;
		endfunction

		task report(input string msg);
			$display("tb: mismatch at result %0d: %s", results_seen, msg);
			errors++;
		endtask

		function void note_item(input calib_points_t p);
			matrix_due.push_back(solve_matrix(p));
		endfunction

		task check_result(input calib_matrix_t got);
			calib_matrix_t want;
			if (matrix_due.size() == 0) begin
				report("result with no item pending");
			end else begin
				want = matrix_due.pop_front();
				if (got.degenerate !== want.degenerate)
					report($sformatf("degenerate %0b, want %0b", got.degenerate, want.degenerate));
				if (got.divider !== want.divider)
					report($sformatf("divider %0d, want %0d", got.divider, want.divider));
				if (got.a !== want.a)
					report($sformatf("coef_a %0d, want %0d", got.a, want.a));
				if (got.b !== want.b)
					report($sformatf("coef_b %0d, want %0d", got.b, want.b));
				if (got.c !== want.c)
					report($sformatf("coef_c %0d, want %0d", got.c, want.c));
				if (got.d !== want.d)
					report($sformatf("coef_d %0d, want %0d", got.d, want.d));
				if (got.e !== want.e)
					report($sformatf("coef_e %0d, want %0d", got.e, want.e));
				if (got.f !== want.f)
					report($sformatf("coef_f %0d, want %0d", got.f, want.f));
			end
			results_seen++;
		endtask

		function int pending();
			return matrix_due.size();
		endfunction

		task close_out();
			while (matrix_due.size() > 0) begin
				report("item never produced a result");
				void'(matrix_due.pop_front());
			end
		endtask
	endclass

	matrix_board board = new();

	function automatic calib_points_t points_on_bus();
		calib_points_t p;
		p.t_x = '{touch0_x, touch1_x, touch2_x};
		p.t_y = '{touch0_y, touch1_y, touch2_y};
		p.d_x = '{disp0_x, disp1_x, disp2_x};
		p.d_y = '{disp0_y, disp1_y, disp2_y};
		return p;
	endfunction

	function automatic calib_matrix_t matrix_on_bus();
		calib_matrix_t m;
		m.degenerate = degenerate;
		m.divider    = divider;
		m.a          = coef_a;
		m.b          = coef_b;
		m.c          = coef_c;
		m.d          = coef_d;
		m.e          = coef_e;
		m.f          = coef_f;
		return m;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_item(points_on_bus());
			if (done)
				board.check_result(matrix_on_bus());
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	function automatic calib_points_t make_points(
			input int t0x, input int t0y, input int t1x, input int t1y,
			input int t2x, input int t2y, input int d0x, input int d0y,
			input int d1x, input int d1y, input int d2x, input int d2y);
		calib_points_t p;
		p.t_x = '{touch_t'(t0x), touch_t'(t1x), touch_t'(t2x)};
		p.t_y = '{touch_t'(t0y), touch_t'(t1y), touch_t'(t2y)};
		p.d_x = '{disp_t'(d0x), disp_t'(d1x), disp_t'(d2x)};
		p.d_y = '{disp_t'(d0y), disp_t'(d1y), disp_t'(d2y)};
		return p;
	endfunction

	function automatic touch_t pick_touch(input int kind);
		case (kind)
			1:       return touch_t'($urandom_range(15));
			2:       return touch_t'(T_MAX - $urandom_range(15));
			3:       return ($urandom_range(1) == 0) ? touch_t'(0) : touch_t'(T_MAX);
			default: return touch_t'($urandom_range(T_MAX));
		endcase
	endfunction

	function automatic disp_t pick_disp(input int kind);
		case (kind)
			1:       return disp_t'($urandom_range(15));
			2:       return disp_t'(D_MAX - $urandom_range(15));
			3:       return ($urandom_range(1) == 0) ? disp_t'(0) : disp_t'(D_MAX);
			default: return disp_t'($urandom_range(D_MAX));
		endcase
	endfunction

	function automatic calib_points_t random_points();
		calib_points_t p;
		int     r, kind, j;
		touch_t sx, sy;
		r = $urandom_range(99);
		if (r < 55)      kind = 0;
		else if (r < 62) kind = 1;
		else if (r < 70) kind = 2;
		else if (r < 80) kind = 3;
		else             kind = 0;
		for (int k = 0; k < 3; k++) begin
			p.t_x[k] = pick_touch(($urandom_range(4) == 0) ? $urandom_range(3) : kind);
			p.t_y[k] = pick_touch(($urandom_range(4) == 0) ? $urandom_range(3) : kind);
			p.d_x[k] = pick_disp(($urandom_range(3) == 0) ? $urandom_range(3) : kind);
			p.d_y[k] = pick_disp(($urandom_range(3) == 0) ? $urandom_range(3) : kind);
		end
		// collinear point sets
		if (r >= 80) begin
			case ($urandom_range(3))
				0: begin
					p.t_x[1] = p.t_x[0];
					p.t_y[1] = p.t_y[0];
				end
				1: p.t_x = '{p.t_x[0], p.t_x[0], p.t_x[0]};
				2: p.t_y = '{p.t_y[0], p.t_y[0], p.t_y[0]};
				default: begin
					p.t_x[1][0] = p.t_x[0][0];
					p.t_y[1][0] = p.t_y[0][0];
					p.t_x[2] = touch_t'(({1'b0, p.t_x[0]} + {1'b0, p.t_x[1]}) >> 1);
					p.t_y[2] = touch_t'(({1'b0, p.t_y[0]} + {1'b0, p.t_y[1]}) >> 1);
				end
			endcase
			j = $urandom_range(2);
			sx = p.t_x[j]; p.t_x[j] = p.t_x[2]; p.t_x[2] = sx;
			sy = p.t_y[j]; p.t_y[j] = p.t_y[2]; p.t_y[2] = sy;
			// nearly collinear
			if (r >= 95)
				p.t_x[$urandom_range(2)][0] ^= 1'b1;
		end
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	task rest(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task send_points(input calib_points_t p);
		@(negedge clk);
		start    <= 1'b1;
		touch0_x <= p.t_x[0];
		touch0_y <= p.t_y[0];
		touch1_x <= p.t_x[1];
		touch1_y <= p.t_y[1];
		touch2_x <= p.t_x[2];
		touch2_y <= p.t_y[2];
		disp0_x  <= p.d_x[0];
		disp0_y  <= p.d_y[0];
		disp1_x  <= p.d_x[1];
		disp1_y  <= p.d_y[1];
		disp2_x  <= p.d_x[2];
		disp2_y  <= p.d_y[2];
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() > 0)
			@(posedge clk);
	endtask

	initial begin
		calib_points_t directed [$];
		bit burst;

		arst_n   = 1'b0;
		start    = 1'b0;
		touch0_x = '0; touch0_y = '0; touch1_x = '0; touch1_y = '0;
		touch2_x = '0; touch2_y = '0;
		disp0_x  = '0; disp0_y  = '0; disp1_x  = '0; disp1_y  = '0;
		disp2_x  = '0; disp2_y  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_points(T_MAX, T_MAX, T_MAX, T_MAX, T_MAX, T_MAX,
			D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX));
		directed.push_back(make_points(T_MAX, 0, 0, T_MAX, 0, 0,
			D_MAX, 0, 0, D_MAX, 0, 0));
		directed.push_back(make_points(0, T_MAX, T_MAX, 0, 0, 0,
			0, D_MAX, D_MAX, 0, 0, 0));
		directed.push_back(make_points(T_MAX, T_MAX, 0, T_MAX, T_MAX, 0,
			D_MAX, D_MAX, 0, D_MAX, D_MAX, 0));
		directed.push_back(make_points(T_MAX, 0, 0, T_MAX, T_MAX, T_MAX,
			0, D_MAX, D_MAX, 0, D_MAX, D_MAX));
		directed.push_back(make_points(0, T_MAX, T_MAX, 0, T_MAX, T_MAX,
			D_MAX, 0, 0, D_MAX, 0, 0));
		directed.push_back(make_points(T_MAX, 0, 0, T_MAX, T_MAX, T_MAX,
			D_MAX, D_MAX, D_MAX, D_MAX, 0, 0));
		// collinear but distinct, nonzero display values
		directed.push_back(make_points(0, 0, 2048, 2048, 4094, 4094,
			1234, 17, 2047, 900, 5, 2000));
		// duplicated point
		directed.push_back(make_points(100, 200, 100, 200, 3000, 50,
			10, 20, 30, 40, 50, 60));
		// vertical and horizontal lines
		directed.push_back(make_points(777, 0, 777, 4095, 777, 1500,
			D_MAX, 0, 0, D_MAX, 1024, 1024));
		directed.push_back(make_points(0, 3333, 4095, 3333, 12, 3333,
			0, 0, D_MAX, D_MAX, 7, 9));
		// divider of +1 and -1
		directed.push_back(make_points(1, 0, 0, 1, 0, 0, D_MAX, D_MAX, 0, D_MAX, D_MAX, 0));
		directed.push_back(make_points(0, 1, 1, 0, 0, 0, D_MAX, 0, D_MAX, D_MAX, 0, D_MAX));
		directed.push_back(make_points(T_MAX, T_MAX, T_MAX - 1, T_MAX - 1, T_MAX, T_MAX - 1,
			D_MAX, 0, 0, D_MAX, D_MAX, D_MAX));
		directed.push_back(make_points('hAAA, 'h555, 'h555, 'hAAA, 'hAAA, 'hAAA,
			'h2AA, 'h555, 'h555, 'h2AA, 'h2AA, 'h555));
		directed.push_back(make_points('h555, 'hAAA, 'hAAA, 'h555, 'h555, 'h555,
			'h555, 'h2AA, 'h2AA, 'h555, 'h555, 'h2AA));
		directed.push_back(make_points(100, 150, 4000, 300, 2000, 3900,
			0, 0, D_MAX, 0, 1024, D_MAX));

		foreach (directed[i])
			send_points(directed[i]);
		wait_drained();

		for (int n = 0; n < 1750; n++) begin
			if (n % 50 == 0)
				burst = ($urandom_range(2) == 0);
			if (n % 400 == 399)
				wait_drained();
			if (!burst)
				rest(pick_gap());
			send_points(random_points());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		board.close_out();
		if (board.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
